>>> rtl/dpt_pkg.sv
// ----------------------------------------------------------------------------
// dpt_pkg
// Shared types, constants and the decay root table of the delivery
// predictability table.
// ----------------------------------------------------------------------------
package dpt_pkg;

	// table geometry
	localparam int DEF_NODES = 64;
	localparam int IDX_W     = 6;
	localparam int PROB_W    = 17;
	localparam logic [PROB_W-1:0] PROB_ONE = 17'h10000;

	// divider geometry
	localparam int DIV_N_W = 56;
	localparam int DIV_D_W = 32;
	localparam int DIV_CNT_W = 6;

	// item kinds
	localparam logic [1:0] KIND_ENC  = 2'd0;
	localparam logic [1:0] KIND_READ = 2'd1;
	localparam logic [1:0] KIND_CMP  = 2'd2;
	localparam logic [1:0] KIND_NONE = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_BIDX = 2'd1;
	localparam logic [1:0] ST_BACK = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_SELF  = 3'd0;
	localparam logic [2:0] REG_MODE  = 3'd1;
	localparam logic [2:0] REG_PINIT = 3'd2;
	localparam logic [2:0] REG_BETA  = 3'd3;
	localparam logic [2:0] REG_NLG   = 3'd4;
	localparam logic [2:0] REG_UNIT  = 3'd5;

	// configuration reset values
	localparam logic [15:0] RST_PINIT = 16'd32768;
	localparam logic [15:0] RST_BETA  = 16'd58982;
	localparam logic [23:0] RST_NLG   = 24'd24216;
	localparam logic [31:0] RST_UNIT  = 32'd3600;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// t_j = 2^-(2^-j) in 0.32, j = 0..24
	typedef logic [31:0] tj_tab_t [0:24];

	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] bitv;
		v = v_in;
		res = 64'd0;
		bitv = 64'd1 << 62;
		for (int k = 0; k < 32; k++) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic tj_tab_t calc_tj();
		tj_tab_t tab;
		logic [63:0] t;
		t = 64'd1 << 31;
		tab[0] = t[31:0];
		for (int j = 1; j <= 24; j++) begin
			t = isqrt64(t << 32);
			tab[j] = t[31:0];
		end
		return tab;
	endfunction

	localparam tj_tab_t TJ_TAB = calc_tj();

endpackage

>>> rtl/delivery_predictability_table_core.sv
// ----------------------------------------------------------------------------
// delivery_predictability_table_core
// Per-node delivery probability table with aging, encounter boost,
// transitive update and peer compare, run by a small sequencer.
// ----------------------------------------------------------------------------
// Usage
//  s_axis: one item per beat. tuser carries kind, tlast marks the final
//  element of an encounter vector. m_axis: one result beat per item.
//  cfg: write cfg_we with cfg_index and cfg_data while the block is idle.
//  When time advances, the elapsed time times the NLG register is divided
//  by the unit register, a decay factor is built from the fraction bits of
//  the quotient, and the aging walk scales every table entry but the own
//  one. The multiplier and divider are shared; s_axis_tready is high only
//  when the sequencer idles. A compare with a better peer divides for the share.
//  A result waits in the output register while the next item is taken.
//  If m_axis_tready stays low, a second result holds the sequencer until
//  the register frees.
//  Reset clears the table at once through per-entry valid bits (entry 0
//  reads 1.0, others 0), sets last aged time to 0 and registers to defaults.
// ----------------------------------------------------------------------------
module delivery_predictability_table_core
	import dpt_pkg::*;
#(
	parameter int NODES = DEF_NODES
) (
	input  logic        clk,
	input  logic        arst_n,
	// input beats
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// now[31:0], enc_node[37:32], index[43:38], peer_value[60:44]
	input  logic [63:0] s_axis_tdata,
	// kind[1:0]
	input  logic [1:0]  s_axis_tuser,
	input  logic        s_axis_tlast,
	// result beats
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// value[16:0], peer_better[17], share[33:18], status[35:34]
	output logic [39:0] m_axis_tdata,
	// configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int DEPTH = (NODES < 64) ? NODES : 64;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_AG_MUL = 5'd1;
	localparam logic [4:0] S_AG_DIV = 5'd2;
	localparam logic [4:0] S_AG_DVW = 5'd3;
	localparam logic [4:0] S_FAC    = 5'd4;
	localparam logic [4:0] S_FAC_W  = 5'd5;
	localparam logic [4:0] S_SHIFT  = 5'd6;
	localparam logic [4:0] S_W_RD   = 5'd7;
	localparam logic [4:0] S_W_MUL  = 5'd8;
	localparam logic [4:0] S_W_WR   = 5'd9;
	localparam logic [4:0] S_OP     = 5'd10;
	localparam logic [4:0] S_B_RD   = 5'd11;
	localparam logic [4:0] S_B_MUL  = 5'd12;
	localparam logic [4:0] S_B_WR   = 5'd13;
	localparam logic [4:0] S_T      = 5'd14;
	localparam logic [4:0] S_T_RD   = 5'd15;
	localparam logic [4:0] S_T_M1   = 5'd16;
	localparam logic [4:0] S_T_M2   = 5'd17;
	localparam logic [4:0] S_T_RD2  = 5'd18;
	localparam logic [4:0] S_T_M3   = 5'd19;
	localparam logic [4:0] S_T_WR   = 5'd20;
	localparam logic [4:0] S_V_RD   = 5'd21;
	localparam logic [4:0] S_V_GET  = 5'd22;
	localparam logic [4:0] S_SH_W   = 5'd23;
	localparam logic [4:0] S_DONE   = 5'd24;

	// configuration registers
	logic [5:0]  self_q;
	logic        mode_q;
	logic [15:0] pinit_q;
	logic [15:0] beta_q;
	logic [23:0] nlg_q;
	logic [31:0] unit_q;

	// control state
	logic [4:0]       state_q;
	logic [31:0]      last_time_q;
	logic             in_enc_q;
	logic [DEPTH-1:0] valid_q;
	logic [AW-1:0]    wi_q;
	logic [4:0]       j_q;
	logic             fone_q;
	logic             m_valid_q;
	logic             res_load;

	// item and working payload
	logic [1:0]         kind_q;
	logic [31:0]        now_q;
	logic [5:0]         enc_q;
	logic [5:0]         idx_q;
	logic [PROB_W-1:0]  pv_q;
	logic               last_q;
	logic [DIV_N_W-1:0] e_q;
	logic [31:0]        f_q;
	logic [31:0]        fac_q;
	logic [PROB_W-1:0]  p_q;
	logic [PROB_W-1:0]  t_q;
	logic [5:0]         rd_idx_q;
	logic [PROB_W-1:0]  res_value_q;
	logic               res_pb_q;
	logic [15:0]        res_share_q;
	logic [1:0]         res_status_q;
	logic [39:0]        m_data_q;

	// input fields
	logic [31:0]       in_now;
	logic [5:0]        in_enc;
	logic [5:0]        in_idx;
	logic [PROB_W-1:0] in_pv;
	logic [PROB_W-1:0] in_pv_sat;
	logic              accept;

	assign in_now    = s_axis_tdata[31:0];
	assign in_enc    = s_axis_tdata[37:32];
	assign in_idx    = s_axis_tdata[43:38];
	assign in_pv     = s_axis_tdata[60:44];
	assign in_pv_sat = (in_pv > PROB_ONE) ? PROB_ONE : in_pv;
	assign s_axis_tready = (state_q == S_IDLE);
	assign accept    = s_axis_tvalid && s_axis_tready;

	// finished result moves into the output register
	assign res_load  = (state_q == S_DONE) && (!m_valid_q || m_axis_tready);

	// shared units
	logic               mul_en;
	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic [63:0]        prod;
	logic               div_start;
	logic [DIV_N_W-1:0] div_n;
	logic [DIV_D_W-1:0] div_d;
	logic [DIV_N_W-1:0] div_quo;
	div_stat_t          div_st;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [PROB_W-1:0]  ram_wdata;
	logic               ram_re;
	logic [5:0]         rd_idx;
	logic [PROB_W-1:0]  ram_rdata;

	dpt_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	dpt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.quo_q    (div_quo),
		.stat     (div_st)
	);

	dpt_ram #(
		.WIDTH (PROB_W),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_idx[AW-1:0]),
		.rdata (ram_rdata)
	);

	// stored entry and own value of the last read
	logic [PROB_W-1:0] stored_rd;
	logic [PROB_W-1:0] own_rd;
	logic [PROB_W-1:0] boost_sum;
	logic [32:0]       shift_in;
	logic [32:0]       shift_out;
	logic [31:0]       unit_eff;
	logic [31:0]       dt;
	logic [17:0]       share_den;
	logic              fbit;

	always_comb begin
		if (valid_q[rd_idx_q[AW-1:0]]) begin
			stored_rd = ram_rdata;
		end else begin
			stored_rd = (rd_idx_q == 6'd0) ? PROB_ONE : '0;
		end
		own_rd = (rd_idx_q == self_q) ? PROB_ONE : stored_rd;
	end

	assign boost_sum = p_q + prod[32:16];
	assign shift_in  = {fone_q, f_q};
	assign shift_out = shift_in >> e_q[29:24];
	assign unit_eff  = (unit_q == 32'd0) ? 32'd1 : unit_q;
	assign dt        = now_q - last_time_q;
	assign share_den = 18'(pv_q) + 18'(own_rd);
	assign fbit      = e_q[5'd24 - j_q];

	// unit operand and memory port selection
	always_comb begin
		mul_en    = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_n     = '0;
		div_d     = '0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		rd_idx    = rd_idx_q;
		case (state_q)
			S_AG_MUL: begin
				mul_en = 1'b1;
				mul_a  = dt;
				mul_b  = 32'(nlg_q);
			end
			S_AG_DIV: begin
				div_start = 1'b1;
				div_n     = prod[DIV_N_W-1:0];
				div_d     = unit_eff;
			end
			S_FAC: begin
				mul_en = 1'b1;
				mul_a  = f_q;
				mul_b  = TJ_TAB[j_q];
			end
			S_W_RD: begin
				if (6'(wi_q) != self_q) begin
					ram_re = 1'b1;
					rd_idx = 6'(wi_q);
				end
			end
			S_W_MUL: begin
				mul_en = 1'b1;
				mul_a  = 32'(stored_rd);
				mul_b  = fac_q;
			end
			S_W_WR: begin
				ram_we    = 1'b1;
				ram_waddr = wi_q;
				ram_wdata = prod[48:32];
			end
			S_B_RD, S_T_RD: begin
				ram_re = 1'b1;
				rd_idx = enc_q;
			end
			S_B_MUL: begin
				mul_en = 1'b1;
				mul_a  = 32'(PROB_ONE - stored_rd);
				mul_b  = 32'(pinit_q);
			end
			S_B_WR: begin
				ram_we    = 1'b1;
				ram_waddr = enc_q[AW-1:0];
				ram_wdata = boost_sum;
			end
			S_T_M1: begin
				mul_en = 1'b1;
				mul_a  = 32'(pv_q);
				mul_b  = 32'(own_rd);
			end
			S_T_M2: begin
				mul_en = 1'b1;
				mul_a  = 32'(prod[32:16]);
				mul_b  = 32'(beta_q);
			end
			S_T_RD2, S_V_RD: begin
				ram_re = 1'b1;
				rd_idx = idx_q;
			end
			S_T_M3: begin
				mul_en = 1'b1;
				mul_a  = 32'(PROB_ONE - stored_rd);
				mul_b  = 32'(t_q);
				if (mode_q && (t_q > stored_rd)) begin
					ram_we    = 1'b1;
					ram_waddr = idx_q[AW-1:0];
					ram_wdata = t_q;
				end
			end
			S_T_WR: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q[AW-1:0];
				ram_wdata = boost_sum;
			end
			S_V_GET: begin
				if ((kind_q == KIND_CMP) && (pv_q > own_rd)) begin
					div_start = 1'b1;
					div_n     = DIV_N_W'({pv_q, 16'd0});
					div_d     = 32'(share_den);
				end
			end
			default: begin
			end
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_q  <= '0;
			mode_q  <= 1'b0;
			pinit_q <= RST_PINIT;
			beta_q  <= RST_BETA;
			nlg_q   <= RST_NLG;
			unit_q  <= RST_UNIT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SELF:  self_q  <= cfg_data[5:0];
				REG_MODE:  mode_q  <= cfg_data[0];
				REG_PINIT: pinit_q <= cfg_data[15:0];
				REG_BETA:  beta_q  <= cfg_data[15:0];
				REG_NLG:   nlg_q   <= cfg_data[23:0];
				REG_UNIT:  unit_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_time_q <= '0;
			in_enc_q    <= 1'b0;
			valid_q     <= '0;
			wi_q        <= '0;
			j_q         <= 5'd1;
			fone_q      <= 1'b1;
			m_valid_q   <= 1'b0;
		end else begin
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (res_load) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (s_axis_tuser == KIND_NONE) begin
							state_q <= S_DONE;
						end else if ((32'(in_idx) >= NODES) ||
							((s_axis_tuser == KIND_ENC) && (32'(in_enc) >= NODES))) begin
							state_q <= S_DONE;
						end else if (in_now < last_time_q) begin
							state_q <= S_DONE;
						end else if (in_now == last_time_q) begin
							state_q <= S_OP;
						end else begin
							state_q <= S_AG_MUL;
						end
					end
				end
				S_AG_MUL: state_q <= S_AG_DIV;
				S_AG_DIV: state_q <= S_AG_DVW;
				S_AG_DVW: begin
					if (div_st.done) begin
						if (div_quo == '0) begin
							state_q <= S_OP;
						end else if (div_quo[DIV_N_W-1:24] >= 32'd33) begin
							state_q <= S_W_RD;
							wi_q    <= '0;
						end else begin
							state_q <= S_FAC;
							j_q     <= 5'd1;
							fone_q  <= 1'b1;
						end
					end
				end
				S_FAC: begin
					if (fbit && !fone_q) begin
						state_q <= S_FAC_W;
					end else begin
						if (fbit) begin
							fone_q <= 1'b0;
						end
						j_q     <= j_q + 1'b1;
						state_q <= (j_q == 5'd24) ? S_SHIFT : S_FAC;
					end
				end
				S_FAC_W: begin
					j_q     <= j_q + 1'b1;
					state_q <= (j_q == 5'd24) ? S_SHIFT : S_FAC;
				end
				S_SHIFT: begin
					state_q <= S_W_RD;
					wi_q    <= '0;
				end
				S_W_RD: begin
					if (6'(wi_q) != self_q) begin
						state_q <= S_W_MUL;
					end else if (wi_q == AW'(DEPTH - 1)) begin
						last_time_q <= now_q;
						state_q     <= S_OP;
					end else begin
						wi_q <= wi_q + 1'b1;
					end
				end
				S_W_MUL: state_q <= S_W_WR;
				S_W_WR: begin
					if (wi_q == AW'(DEPTH - 1)) begin
						last_time_q <= now_q;
						state_q     <= S_OP;
					end else begin
						wi_q    <= wi_q + 1'b1;
						state_q <= S_W_RD;
					end
				end
				S_OP: begin
					if (kind_q == KIND_ENC) begin
						if (!in_enc_q) begin
							in_enc_q <= 1'b1;
							state_q  <= (enc_q != self_q) ? S_B_RD : S_T;
						end else begin
							state_q <= S_T;
						end
					end else begin
						state_q <= S_V_RD;
					end
				end
				S_B_RD:  state_q <= S_B_MUL;
				S_B_MUL: state_q <= S_B_WR;
				S_B_WR:  state_q <= S_T;
				S_T: begin
					if ((idx_q != self_q) && (idx_q != enc_q)) begin
						state_q <= S_T_RD;
					end else begin
						state_q <= S_V_RD;
					end
				end
				S_T_RD:  state_q <= S_T_M1;
				S_T_M1:  state_q <= S_T_M2;
				S_T_M2:  state_q <= S_T_RD2;
				S_T_RD2: state_q <= S_T_M3;
				S_T_M3:  state_q <= mode_q ? S_V_RD : S_T_WR;
				S_T_WR:  state_q <= S_V_RD;
				S_V_RD: begin
					if ((kind_q == KIND_ENC) && last_q) begin
						in_enc_q <= 1'b0;
					end
					state_q <= S_V_GET;
				end
				S_V_GET: state_q <= div_start ? S_SH_W : S_DONE;
				S_SH_W: begin
					if (div_st.done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working data
	always_ff @(posedge clk) begin
		if (ram_re) begin
			rd_idx_q <= rd_idx;
		end
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					kind_q       <= s_axis_tuser;
					now_q        <= in_now;
					enc_q        <= in_enc;
					idx_q        <= in_idx;
					pv_q         <= in_pv_sat;
					last_q       <= s_axis_tlast;
					res_value_q  <= '0;
					res_pb_q     <= 1'b0;
					res_share_q  <= '0;
					res_status_q <= ST_OK;
					if (s_axis_tuser != KIND_NONE) begin
						if ((32'(in_idx) >= NODES) ||
							((s_axis_tuser == KIND_ENC) && (32'(in_enc) >= NODES))) begin
							res_status_q <= ST_BIDX;
						end else if (in_now < last_time_q) begin
							res_status_q <= ST_BACK;
						end
					end
				end
			end
			S_AG_DVW: begin
				if (div_st.done) begin
					e_q   <= div_quo;
					fac_q <= '0;
				end
			end
			S_FAC: begin
				if (fbit && fone_q) begin
					f_q <= TJ_TAB[j_q];
				end
			end
			S_FAC_W: f_q <= prod[63:32];
			S_SHIFT: fac_q <= shift_out[31:0];
			S_B_MUL, S_T_M3: p_q <= stored_rd;
			S_T_RD2: t_q <= prod[32:16];
			S_V_GET: res_value_q <= own_rd;
			S_SH_W: begin
				if (div_st.done) begin
					res_pb_q    <= 1'b1;
					res_share_q <= (div_quo > DIV_N_W'(16'hFFFF)) ? 16'hFFFF : div_quo[15:0];
				end
			end
			default: begin
			end
		endcase
		if (res_load) begin
			m_data_q <= {4'd0, res_status_q, res_share_q, res_pb_q, res_value_q};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("input taken again before the item finished");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_st.busy)
		else $error("divider started while busy");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) && (!m_axis_tvalid || m_axis_tready) |=> m_axis_tvalid)
		else $error("finished result not presented");

	a_walk_ends_op: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_W_WR) && (wi_q == AW'(DEPTH - 1)) |=> (state_q == S_OP))
		else $error("aging walk did not hand over to the operation");

endmodule

>>> rtl/dpt_ram.sv
// ----------------------------------------------------------------------------
// dpt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dpt_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/dpt_mul.sv
// ----------------------------------------------------------------------------
// dpt_mul
// Shared 32 x 32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module dpt_mul (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] prod_q
);

	// one product per cycle, held when idle
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= 64'(a) * 64'(b);
		end
	end

endmodule

>>> rtl/dpt_div.sv
// ----------------------------------------------------------------------------
// dpt_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dpt_div
	import dpt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIV_N_W-1:0] dividend,
	input  logic [DIV_D_W-1:0] divisor,
	output logic [DIV_N_W-1:0] quo_q,
	output div_stat_t          stat
);

	logic [DIV_D_W-1:0]   rem_q;
	logic [DIV_D_W-1:0]   dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_D_W:0]     shifted;
	logic                 fits;

	// trial subtract of one step
	assign shifted = {rem_q, quo_q[DIV_N_W-1]};
	assign fits    = shifted >= {1'b0, dsr_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DIV_D_W'(shifted - {1'b0, dsr_q}) : shifted[DIV_D_W-1:0];
			quo_q <= {quo_q[DIV_N_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule
